// ----- src/rotary_encoder_with_button_decoder_macros.svh -----
// Assertion macros for the rotary encoder and button decoder checker.
`ifndef ROTARY_ENCODER_WITH_BUTTON_DECODER_MACROS_SVH
`define ROTARY_ENCODER_WITH_BUTTON_DECODER_MACROS_SVH

// check that is off while reset is high
`define REBD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// check that also runs through reset
`define REBD_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- src/rebd_pkg.sv -----
// Shared types and constants for the rotary encoder and button decoder.
package rebd_pkg;

  typedef enum logic [1:0] {
    ROT_NONE = 2'd0,
    ROT_CW   = 2'd1,
    ROT_CCW  = 2'd2
  } rot_t;

  typedef enum logic [1:0] {
    BTN_NONE      = 2'd0,
    BTN_SHORT     = 2'd1,
    BTN_LONG      = 2'd2,
    BTN_VERY_LONG = 2'd3
  } btn_t;

  typedef enum logic [1:0] {
    REG_STEP_DIVISOR    = 2'd0,
    REG_SHORT_LIMIT     = 2'd1,
    REG_LONG_LIMIT      = 2'd2,
    REG_VERY_LONG_LIMIT = 2'd3
  } reg_idx_t;

  localparam logic [6:0]  STEP_DIVISOR_RST    = 7'd1;
  localparam logic [15:0] SHORT_LIMIT_RST     = 16'd50;
  localparam logic [15:0] LONG_LIMIT_RST      = 16'd500;
  localparam logic [15:0] VERY_LONG_LIMIT_RST = 16'd2000;
  localparam logic [15:0] HOLD_MAX            = 16'hFFFF;

  typedef struct packed {
    logic [6:0]  step_divisor;
    logic [15:0] short_limit;
    logic [15:0] long_limit;
    logic [15:0] very_long_limit;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  last_position;
    logic [7:0]  step_accumulator;
    logic [15:0] hold_ticks;
  } state_t;

endpackage

// ----- src/rebd_update.sv -----
// Per-sample update: position decode, step accumulation and hold classification.
module rebd_update (
  input  rebd_pkg::cfg_t   cfg,
  input  rebd_pkg::state_t state,
  input  logic             pin_a,
  input  logic             pin_b,
  input  logic             pin_button,
  output rebd_pkg::state_t state_next,
  output rebd_pkg::rot_t   rot,
  output rebd_pkg::btn_t   btn
);

  logic [1:0] pos;
  logic [1:0] diff;
  logic [7:0] acc_inc;
  logic [7:0] acc_dec;
  logic [7:0] div_ext;
  logic [15:0] hold;

  assign pos     = {~pin_b, pin_a ^ pin_b};
  assign diff    = pos - state.last_position;
  assign acc_inc = state.step_accumulator + 8'd1;
  assign acc_dec = state.step_accumulator - 8'd1;
  assign div_ext = {1'b0, cfg.step_divisor};
  assign hold    = state.hold_ticks;

  always_comb begin
    state_next = state;
    state_next.last_position = pos;
    rot = rebd_pkg::ROT_NONE;
    btn = rebd_pkg::BTN_NONE;

    if (diff == 2'd3) begin
      if (acc_inc == div_ext) begin
        state_next.step_accumulator = 8'd0;
        rot = rebd_pkg::ROT_CW;
      end else begin
        state_next.step_accumulator = acc_inc;
      end
    end else if (diff == 2'd1) begin
      if (acc_dec == (8'd0 - div_ext)) begin
        state_next.step_accumulator = 8'd0;
        rot = rebd_pkg::ROT_CCW;
      end else begin
        state_next.step_accumulator = acc_dec;
      end
    end

    // later tests win when limits are out of order
    if (hold != 16'd0 && pin_button) begin
      if (cfg.short_limit < hold && hold < cfg.long_limit) begin
        btn = rebd_pkg::BTN_SHORT;
      end
      if (cfg.long_limit < hold && hold < cfg.very_long_limit) begin
        btn = rebd_pkg::BTN_LONG;
      end
      if (cfg.very_long_limit < hold) begin
        btn = rebd_pkg::BTN_VERY_LONG;
      end
      state_next.hold_ticks = 16'd0;
    end else if (!pin_button && hold != rebd_pkg::HOLD_MAX) begin
      state_next.hold_ticks = hold + 16'd1;
    end
  end

endmodule

// ----- src/rotary_encoder_with_button_decoder.sv -----
// Top level of the rotary encoder and push button decoder.
//
// Input channel (in_valid / in_stall): one sample of pin_a, pin_b and
// pin_button per item, all active low. An item is taken at an edge where
// in_valid is high and in_stall is low.
// Output channel (out_valid / out_stall): an item carries rotate_event and
// button_event and is sent only when at least one of them is nonzero;
// samples without an event leave no output.
// Config channel (cfg_valid / cfg_ready): cfg_index selects step_divisor,
// short_limit, long_limit or very_long_limit; cfg_ready is always high.
// Write only while no sample is in flight.
// A taken sample waits in the input register; its result goes to the result
// register when the output is free. Throughput: one sample per cycle while
// no result is stalled, set by the combinational state update between them.
// When out_stall holds a result, the input register still takes one sample;
// in_stall then rises until the result is taken.
// Reset clears decoder state and the valid bits of both pipeline registers
// and loads the register defaults (1, 50, 500, 2000).
module rotary_encoder_with_button_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        pin_a,
  input  logic        pin_b,
  input  logic        pin_button,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  rotate_event,
  output logic [1:0]  button_event,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  rebd_pkg::cfg_t   cfg;
  rebd_pkg::state_t state;
  rebd_pkg::state_t state_next;
  rebd_pkg::rot_t   rot;
  rebd_pkg::btn_t   btn;

  logic s1_valid;
  logic s1_a;
  logic s1_b;
  logic s1_button;
  logic out_free;
  logic advance;

  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || !out_stall;
  assign advance   = s1_valid && out_free;
  assign in_stall  = s1_valid && !out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.step_divisor    <= rebd_pkg::STEP_DIVISOR_RST;
      cfg.short_limit     <= rebd_pkg::SHORT_LIMIT_RST;
      cfg.long_limit      <= rebd_pkg::LONG_LIMIT_RST;
      cfg.very_long_limit <= rebd_pkg::VERY_LONG_LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (rebd_pkg::reg_idx_t'(cfg_index))
        rebd_pkg::REG_STEP_DIVISOR:    cfg.step_divisor    <= cfg_data[6:0];
        rebd_pkg::REG_SHORT_LIMIT:     cfg.short_limit     <= cfg_data;
        rebd_pkg::REG_LONG_LIMIT:      cfg.long_limit      <= cfg_data;
        rebd_pkg::REG_VERY_LONG_LIMIT: cfg.very_long_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_a      <= pin_a;
      s1_b      <= pin_b;
      s1_button <= pin_button;
    end
  end

  rebd_update u_update (
    .cfg        (cfg),
    .state      (state),
    .pin_a      (s1_a),
    .pin_b      (s1_b),
    .pin_button (s1_button),
    .state_next (state_next),
    .rot        (rot),
    .btn        (btn)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= advance &&
                   (rot != rebd_pkg::ROT_NONE || btn != rebd_pkg::BTN_NONE);
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rotate_event <= rot;
      button_event <= btn;
    end
  end

endmodule

// ----- src/rebd_checker.sv -----
// Port-level checks for the rotary encoder and button decoder, bound to the top.
`include "rotary_encoder_with_button_decoder_macros.svh"

module rebd_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [1:0] rotate_event,
  input logic [1:0] button_event
);

  `REBD_ASSERT(a_hold_stalled, out_valid && out_stall |=> out_valid && $stable(rotate_event) && $stable(button_event), "stalled result changed")
  `REBD_ASSERT(a_has_event, out_valid |-> (rotate_event != 2'd0 || button_event != 2'd0), "result without event")
  `REBD_ASSERT(a_rot_code, out_valid |-> rotate_event != 2'd3, "bad rotation code")
  `REBD_ASSERT_RST(a_reset_idle, rst |=> !out_valid && !in_stall, "not idle after reset")

endmodule

bind rotary_encoder_with_button_decoder rebd_checker u_rebd_checker (.*);
